>>> rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared codes and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] cls_t;

  localparam kind_t KIND_INF  = 2'd0;
  localparam kind_t KIND_NONE = 2'd1;
  localparam kind_t KIND_ONE  = 2'd2;
  localparam kind_t KIND_TWO  = 2'd3;

  localparam cls_t CLS_INF  = 2'd0;
  localparam cls_t CLS_NONE = 2'd1;
  localparam cls_t CLS_LIN  = 2'd2;
  localparam cls_t CLS_QUAD = 2'd3;

  localparam int RFRAC = 16;

endpackage

>>> rtl/core/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Sign split, coefficient products and exact discriminant over three stages.
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int W      = 16,
  parameter int DW     = 2 * W + 1,
  parameter int SIDE_W = 3 * W + 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [W-1:0]      coef_a,
  input  logic [W-1:0]      coef_b,
  input  logic [W-1:0]      coef_c,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [DW-1:0]     dn_disc,
  output logic [SIDE_W-1:0] dn_side
);

  logic          v0_r, v1_r, v2_r;
  logic          rdy0, rdy1, rdy2;
  logic [2:0]    sg0_r, sg1_r;
  logic [W-1:0]  am0_r, bm0_r, cm0_r;
  logic [W-1:0]  am1_r, bm1_r, cm1_r;
  logic [2*W-1:0] b2_r, ac_r;
  logic [DW-1:0] disc_r, disc_nxt;
  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [W-1:0]  am_nxt, bm_nxt, cm_nxt;
  logic [DW-1:0] b2x, ac4, dsum, ddif;
  logic          opp, dge, dneg, az, bz, cz;
  qrs_pkg::cls_t cls;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign up_ready = rdy0;

  assign am_nxt = coef_a[W-1] ? (~coef_a + W'(1)) : coef_a;
  assign bm_nxt = coef_b[W-1] ? (~coef_b + W'(1)) : coef_b;
  assign cm_nxt = coef_c[W-1] ? (~coef_c + W'(1)) : coef_c;

  assign b2x  = {1'b0, b2_r};
  assign ac4  = {ac_r[2*W-2:0], 2'b00};
  assign dsum = b2x + ac4;
  assign ddif = b2x - ac4;
  assign dge  = b2x >= ac4;
  assign az   = am1_r == '0;
  assign bz   = bm1_r == '0;
  assign cz   = cm1_r == '0;
  assign opp  = !cz && (sg1_r[2] != sg1_r[0]);
  assign dneg = !opp && !dge;
  assign disc_nxt = opp ? dsum : ddif;

  always_comb begin
    if (az && bz) begin
      cls = cz ? qrs_pkg::CLS_INF : qrs_pkg::CLS_NONE;
    end else if (az) begin
      cls = qrs_pkg::CLS_LIN;
    end else if (dneg) begin
      cls = qrs_pkg::CLS_NONE;
    end else begin
      cls = qrs_pkg::CLS_QUAD;
    end
  end

  assign side_nxt = {cls, sg1_r, am1_r, bm1_r, cm1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= up_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy0) begin
      sg0_r <= {coef_a[W-1], coef_b[W-1], coef_c[W-1]};
      am0_r <= am_nxt;
      bm0_r <= bm_nxt;
      cm0_r <= cm_nxt;
    end
    if (v0_r && rdy1) begin
      sg1_r <= sg0_r;
      am1_r <= am0_r;
      bm1_r <= bm0_r;
      cm1_r <= cm0_r;
      b2_r  <= bm0_r * bm0_r;
      ac_r  <= am0_r * cm0_r;
    end
    if (v1_r && rdy2) begin
      disc_r <= disc_nxt;
      side_r <= side_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_disc  = disc_r;
  assign dn_side  = side_r;

endmodule

>>> rtl/core/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One root bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int SW     = 33,
  parameter int SIDE_W = 53
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [2*SW-1:0]   up_rad,
  input  logic [SW:0]       up_rem,
  input  logic [SW-1:0]     up_root,
  input  logic [SIDE_W-1:0] up_side,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [2*SW-1:0]   dn_rad,
  output logic [SW:0]       dn_rem,
  output logic [SW-1:0]     dn_root,
  output logic [SIDE_W-1:0] dn_side
);

  logic              valid_r;
  logic [2*SW-1:0]   rad_r;
  logic [SW:0]       rem_r, rem_nxt;
  logic [SW-1:0]     root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [SW+2:0]     rem2, trial, diff;
  logic              ge;

  assign up_ready = !valid_r || dn_ready;

  assign rem2     = {up_rem, up_rad[2*SW-1 -: 2]};
  assign trial    = {1'b0, up_root, 2'b01};
  assign ge       = rem2 >= trial;
  assign diff     = rem2 - trial;
  assign rem_nxt  = ge ? diff[SW:0] : rem2[SW:0];
  assign root_nxt = {up_root[SW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rad_r  <= {up_rad[2*SW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rad   = rad_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_side  = side_r;

endmodule

>>> rtl/core/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of a restoring divide, for both root lanes.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int NW     = 34,
  parameter int DENW   = 17,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [NW-1:0]     up_nq   [2],
  input  logic [DENW-1:0]   up_rem  [2],
  input  logic [DENW-1:0]   up_den  [2],
  input  logic [SIDE_W-1:0] up_side,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [NW-1:0]     dn_nq   [2],
  output logic [DENW-1:0]   dn_rem  [2],
  output logic [DENW-1:0]   dn_den  [2],
  output logic [SIDE_W-1:0] dn_side
);

  logic              valid_r;
  logic [NW-1:0]     nq_r   [2];
  logic [DENW-1:0]   rem_r  [2];
  logic [DENW-1:0]   den_r  [2];
  logic [NW-1:0]     nq_nxt [2];
  logic [DENW-1:0]   rem_nxt[2];
  logic [SIDE_W-1:0] side_r;

  assign up_ready = !valid_r || dn_ready;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DENW:0] rem2, diff;
    logic          ge;
    assign rem2       = {up_rem[l], up_nq[l][NW-1]};
    assign ge         = rem2 >= {1'b0, up_den[l]};
    assign diff       = rem2 - {1'b0, up_den[l]};
    assign rem_nxt[l] = ge ? diff[DENW-1:0] : rem2[DENW-1:0];
    assign nq_nxt[l]  = {up_nq[l][NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      nq_r   <= nq_nxt;
      rem_r  <= rem_nxt;
      den_r  <= up_den;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_nq    = nq_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den_r;
  assign dn_side  = side_r;

endmodule

>>> rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 from fixed-point coefficients.
// ----------------------------------------------------------------------------
// Input beat: in_tdata carries coef_a, coef_b, coef_c (COEF_WIDTH bits each,
// signed, one shared fixed-point scale). Output beat: out_tdata carries
// root_one and root_two (signed Q16.16, ROOT_WIDTH bits), out_tuser carries
// root_kind (0 infinite, 1 none, 2 one, 3 two) and the saturated flag.
// Every input beat yields exactly one output beat, in order.
// Pipeline: three front stages, one cell per square-root bit
// (COEF_WIDTH + 17), one numerator stage, one cell per quotient bit
// (COEF_WIDTH + 18), one output register. Throughput: one beat per cycle
// unless stalled; every cell takes a new beat each cycle when not stalled.
// Each stage holds its beat while the one after it is full and stalled, so
// a stall at out_tready fills the chain back towards in_tready, and bubbles
// close up. Reset clears all valid flags; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int ROOT_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // coef_a, coef_b, coef_c, zero padding
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // root_one, root_two, zero padding
  output logic [((2*ROOT_WIDTH+7)/8)*8-1:0]     out_tdata,
  // root_kind, saturated, zero padding
  output logic [7:0]                            out_tuser
);

  localparam int W      = COEF_WIDTH;
  localparam int RW     = ROOT_WIDTH;
  localparam int RF     = qrs_pkg::RFRAC;
  localparam int DW     = 2 * W + 1;
  localparam int SW     = (DW + 2 * RF + 1) / 2;
  localparam int NW     = ((W + RF) > SW ? (W + RF) : SW) + 1;
  localparam int NSW    = NW + 1;
  localparam int DENW   = W + 1;
  localparam int SIDE_W = 3 * W + 5;
  localparam int DSIDE  = 4;
  localparam int CW     = (NW > RW ? NW : RW) + 1;
  localparam int ODW    = ((2 * RW + 7) / 8) * 8;
  localparam logic [CW-1:0] MAXPOS = {{(CW-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic [CW-1:0] MAXNEG = MAXPOS + CW'(1);

  // front
  logic              fr_valid, fr_ready;
  logic [DW-1:0]     fr_disc;
  logic [SIDE_W-1:0] fr_side;

  qrs_front #(.W(W), .DW(DW), .SIDE_W(SIDE_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .coef_a   (in_tdata[W-1:0]),
    .coef_b   (in_tdata[2*W-1:W]),
    .coef_c   (in_tdata[3*W-1:2*W]),
    .dn_valid (fr_valid),
    .dn_ready (fr_ready),
    .dn_disc  (fr_disc),
    .dn_side  (fr_side)
  );

  // square-root chain
  logic              sq_valid [SW+1];
  logic              sq_ready [SW+1];
  logic [2*SW-1:0]   sq_rad   [SW+1];
  logic [SW:0]       sq_rem   [SW+1];
  logic [SW-1:0]     sq_root  [SW+1];
  logic [SIDE_W-1:0] sq_side  [SW+1];

  assign sq_valid[0] = fr_valid;
  assign fr_ready    = sq_ready[0];
  assign sq_rad[0]   = {1'b0, fr_disc, {(2*RF){1'b0}}};
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = fr_side;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_valid[i]),
      .up_ready (sq_ready[i]),
      .up_rad   (sq_rad[i]),
      .up_rem   (sq_rem[i]),
      .up_root  (sq_root[i]),
      .up_side  (sq_side[i]),
      .dn_valid (sq_valid[i+1]),
      .dn_ready (sq_ready[i+1]),
      .dn_rad   (sq_rad[i+1]),
      .dn_rem   (sq_rem[i+1]),
      .dn_root  (sq_root[i+1]),
      .dn_side  (sq_side[i+1])
    );
  end

  // numerator stage
  logic                 nm_valid_r, nm_ready;
  logic [NW-1:0]        nm_nq_r  [2];
  logic [DENW-1:0]      nm_den_r [2];
  logic [DSIDE-1:0]     nm_side_r;
  logic [NW-1:0]        nq_nxt   [2];
  logic [DENW-1:0]      den_nxt  [2];
  logic [DSIDE-1:0]     dside_nxt;
  logic [SIDE_W-1:0]    sd;
  logic [SW-1:0]        sroot;
  qrs_pkg::cls_t        cls;
  qrs_pkg::kind_t       kind_nxt;
  logic                 an, bn, cn;
  logic [W-1:0]         am, bm, cm;
  logic signed [NSW-1:0] nb, n1, n2;
  logic [NSW-1:0]       n1m, n2m;
  logic                 neg0, neg1;

  assign sd    = sq_side[SW];
  assign sroot = sq_root[SW];
  assign cls   = sd[3*W+4:3*W+3];
  assign an    = sd[3*W+2];
  assign bn    = sd[3*W+1];
  assign cn    = sd[3*W];
  assign am    = sd[3*W-1:2*W];
  assign bm    = sd[2*W-1:W];
  assign cm    = sd[W-1:0];

  assign nb  = bn ? $signed({{(NSW-W-RF){1'b0}}, bm, {RF{1'b0}}})
                  : -$signed({{(NSW-W-RF){1'b0}}, bm, {RF{1'b0}}});
  assign n1  = nb - $signed({{(NSW-SW){1'b0}}, sroot});
  assign n2  = nb + $signed({{(NSW-SW){1'b0}}, sroot});
  assign n1m = n1[NSW-1] ? NSW'(-n1) : NSW'(n1);
  assign n2m = n2[NSW-1] ? NSW'(-n2) : NSW'(n2);

  always_comb begin
    nq_nxt[1]  = n2m[NW-1:0];
    den_nxt[1] = {am, 1'b0};
    unique case (cls)
      qrs_pkg::CLS_LIN: begin
        nq_nxt[0] = {{(NW-W-RF){1'b0}}, cm, {RF{1'b0}}};
        den_nxt[0] = {1'b0, bm};
        neg0       = (cm != '0) && (cn == bn);
        kind_nxt   = qrs_pkg::KIND_ONE;
      end
      qrs_pkg::CLS_QUAD: begin
        nq_nxt[0]  = n1m[NW-1:0];
        den_nxt[0] = {am, 1'b0};
        neg0       = n1[NSW-1] != an;
        kind_nxt   = (sroot == '0) ? qrs_pkg::KIND_ONE : qrs_pkg::KIND_TWO;
      end
      qrs_pkg::CLS_INF: begin
        nq_nxt[0]  = '0;
        den_nxt[0] = {am, 1'b0};
        neg0       = 1'b0;
        kind_nxt   = qrs_pkg::KIND_INF;
      end
      default: begin
        nq_nxt[0]  = '0;
        den_nxt[0] = {am, 1'b0};
        neg0       = 1'b0;
        kind_nxt   = qrs_pkg::KIND_NONE;
      end
    endcase
  end

  assign neg1       = n2[NSW-1] != an;
  assign dside_nxt  = {kind_nxt, neg1, neg0};

  logic dv_ready0;
  assign sq_ready[SW] = !nm_valid_r || dv_ready0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_valid_r <= 1'b0;
    end else if (sq_ready[SW]) begin
      nm_valid_r <= sq_valid[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid[SW] && sq_ready[SW]) begin
      nm_nq_r   <= nq_nxt;
      nm_den_r  <= den_nxt;
      nm_side_r <= dside_nxt;
    end
  end

  // divide chain
  logic             dv_valid [NW+1];
  logic             dv_ready [NW+1];
  logic [NW-1:0]    dv_nq    [NW+1][2];
  logic [DENW-1:0]  dv_rem   [NW+1][2];
  logic [DENW-1:0]  dv_den   [NW+1][2];
  logic [DSIDE-1:0] dv_side  [NW+1];

  assign dv_valid[0]  = nm_valid_r;
  assign dv_ready0    = dv_ready[0];
  assign dv_nq[0]     = nm_nq_r;
  assign dv_rem[0][0] = '0;
  assign dv_rem[0][1] = '0;
  assign dv_den[0]    = nm_den_r;
  assign dv_side[0]   = nm_side_r;

  for (genvar i = 0; i < NW; i++) begin : g_div
    qrs_div_cell #(.NW(NW), .DENW(DENW), .SIDE_W(DSIDE)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[i]),
      .up_ready (dv_ready[i]),
      .up_nq    (dv_nq[i]),
      .up_rem   (dv_rem[i]),
      .up_den   (dv_den[i]),
      .up_side  (dv_side[i]),
      .dn_valid (dv_valid[i+1]),
      .dn_ready (dv_ready[i+1]),
      .dn_nq    (dv_nq[i+1]),
      .dn_rem   (dv_rem[i+1]),
      .dn_den   (dv_den[i+1]),
      .dn_side  (dv_side[i+1])
    );
  end

  // saturation and output register
  logic [RW-1:0]  val  [2];
  logic           over [2];
  qrs_pkg::kind_t kind;
  logic           is_one_plus, is_two;

  assign kind = dv_side[NW][3:2];

  for (genvar l = 0; l < 2; l++) begin : g_sat
    logic [CW-1:0] qx, lim, mag, sgn;
    logic          neg;
    assign neg     = dv_side[NW][l];
    assign qx      = CW'(dv_nq[NW][l]);
    assign lim     = neg ? MAXNEG : MAXPOS;
    assign over[l] = qx > lim;
    assign mag     = over[l] ? lim : qx;
    assign sgn     = neg ? (~mag + CW'(1)) : mag;
    assign val[l]  = sgn[RW-1:0];
  end

  assign is_one_plus = (kind == qrs_pkg::KIND_ONE) || (kind == qrs_pkg::KIND_TWO);
  assign is_two      = kind == qrs_pkg::KIND_TWO;

  logic           out_valid_r;
  logic [RW-1:0]  root_one_r, root_two_r;
  qrs_pkg::kind_t kind_r;
  logic           sat_r;

  assign dv_ready[NW] = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready[NW]) begin
      out_valid_r <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_valid[NW] && dv_ready[NW]) begin
      kind_r     <= kind;
      root_one_r <= is_one_plus ? val[0] : '0;
      root_two_r <= is_two ? val[1] : '0;
      sat_r      <= (is_one_plus && over[0]) || (is_two && over[1]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ODW-2*RW){1'b0}}, root_two_r, root_one_r};
  assign out_tuser  = {5'b00000, sat_r, kind_r};

endmodule

>>> rtl/core/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker #(
  parameter int ODW = 64,
  parameter int RW  = 32
) (
  input logic           clk,
  input logic           rst_n,
  input logic           out_tvalid,
  input logic           out_tready,
  input logic [ODW-1:0] out_tdata,
  input logic [7:0]     out_tuser
);

  logic zero_kind;
  assign zero_kind = (out_tuser[1:0] == qrs_pkg::KIND_INF) ||
                     (out_tuser[1:0] == qrs_pkg::KIND_NONE);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled beat changed");

  a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && zero_kind |-> out_tdata[2*RW-1:0] == '0 && !out_tuser[2])
    else $error("roots reported without a root");

  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != qrs_pkg::KIND_TWO |-> out_tdata[2*RW-1:RW] == '0)
    else $error("second root without two roots");

endmodule

bind quadratic_root_solver qrs_checker #(
  .ODW (((2*ROOT_WIDTH+7)/8)*8),
  .RW  (ROOT_WIDTH)
) u_qrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> bench/tb_quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Self-checking bench for the quadratic root solver: a directed table of
// coefficient triples, then random triples (mostly chosen to give real roots),
// all predicted by an exact-arithmetic root predictor and compared per field.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int RW = 32;
  localparam int N_RANDOM = 1950;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [RW-1:0]  root_two;
    logic [RW-1:0]  root_one;
    logic           sat;
    qrs_pkg::kind_t kind;
  } roots_t;

  typedef struct {
    logic [CW-1:0] a, b, c;
    logic          known;
    roots_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [7:0] out_tuser;

  roots_t expected_roots[$];
  bit failed = 1'b0;
  int idle_cycles = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  quadratic_root_solver #(.COEF_WIDTH(CW), .ROOT_WIDTH(RW)) dut (.*);

  function automatic logic [RW-1:0] div_clip(bit neg, logic [127:0] num, logic [127:0] den,
                                             ref bit sat);
    logic [127:0] q;
    logic [127:0] maxpos;
    maxpos = (128'd1 << (RW - 1)) - 1;
    q = num / den;
    if (q == 0) return '0;
    if (!neg) begin
      if (q > maxpos) begin
        sat = 1'b1;
        q = maxpos;
      end
      return q[RW-1:0];
    end
    if (q > maxpos + 1) begin
      sat = 1'b1;
      q = maxpos + 1;
    end
    return RW'(-q);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= d) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
    roots_t r;
    bit sat;
    logic signed [127:0] sa, sb, sc, d, nb, n1, n2, s;
    sat = 1'b0;
    r = '0;
    sa = $signed(a);
    sb = $signed(b);
    sc = $signed(c);
    if (sa == 0 && sb == 0) begin
      r.kind = (sc == 0) ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
    end else if (sa == 0) begin
      r.kind = qrs_pkg::KIND_ONE;
      r.root_one = div_clip(sc != 0 && ((sc < 0) == (sb < 0)),
                            (sc < 0 ? -sc : sc) << qrs_pkg::RFRAC, sb < 0 ? -sb : sb, sat);
    end else begin
      d = sb * sb - 4 * sa * sc;
      if (d < 0) begin
        r.kind = qrs_pkg::KIND_NONE;
      end else begin
        s = isqrt(d << (2 * qrs_pkg::RFRAC));
        nb = -(sb <<< qrs_pkg::RFRAC);
        n1 = nb - s;
        n2 = nb + s;
        r.root_one = div_clip((n1 < 0) != (sa < 0), n1 < 0 ? -n1 : n1,
                              2 * (sa < 0 ? -sa : sa), sat);
        if (s == 0) begin
          r.kind = qrs_pkg::KIND_ONE;
        end else begin
          r.kind = qrs_pkg::KIND_TWO;
          r.root_two = div_clip((n2 < 0) != (sa < 0), n2 < 0 ? -n2 : n2,
                                2 * (sa < 0 ? -sa : sa), sat);
        end
      end
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic row_t mk(int a, int b, int c, bit known = 0,
                              qrs_pkg::kind_t k = qrs_pkg::KIND_INF,
                              int r1 = 0, int r2 = 0, bit s = 0);
    row_t t;
    t.a = a[CW-1:0];
    t.b = b[CW-1:0];
    t.c = c[CW-1:0];
    t.known = known;
    t.res = '{root_two: r2, root_one: r1, sat: s, kind: k};
    return t;
  endfunction

  task automatic send_triple(row_t t);
    roots_t p;
    while ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : 1) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t.c, t.b, t.a};
    p = solve_roots(t.a, t.b, t.c);
    if (t.known && p != t.res) begin
      $error("table row disagrees with predictor: %h vs %h", t.res, p);
      failed = 1'b1;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_roots.push_back(p);
  endtask

  function automatic logic [CW-1:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 1) ? 16'h7fff : 16'h8000) ^ CW'($urandom_range(0, 3));
      1: return CW'($signed($urandom_range(0, 64)) - 32);
      2: return 0;
      default: return CW'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        roots_t e;
        if (expected_roots.size() == 0) begin
          $error("unexpected result beat");
          failed = 1'b1;
        end else begin
          e = expected_roots.pop_front();
          if (out_tuser[1:0] !== e.kind) begin
            $error("root_kind expected %0d got %0d", e.kind, out_tuser[1:0]);
            failed = 1'b1;
          end
          if (out_tdata[31:0] !== e.root_one) begin
            $error("root_one expected %h got %h", e.root_one, out_tdata[31:0]);
            failed = 1'b1;
          end
          if (out_tdata[63:32] !== e.root_two) begin
            $error("root_two expected %h got %h", e.root_two, out_tdata[63:32]);
            failed = 1'b1;
          end
          if (out_tuser[2] !== e.sat) begin
            $error("saturated expected %0d got %0d", e.sat, out_tuser[2]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    row_t dir[$];
    row_t t;
    int a, r1, r2, k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dir.push_back(mk(0, 0, 0, 1, qrs_pkg::KIND_INF));
    dir.push_back(mk(0, 0, 5, 1, qrs_pkg::KIND_NONE));
    dir.push_back(mk(0, 0, -32768, 1, qrs_pkg::KIND_NONE));
    dir.push_back(mk(0, 256, -512, 1, qrs_pkg::KIND_ONE, 32'h20000));
    dir.push_back(mk(0, 1, 32767, 1, qrs_pkg::KIND_ONE, 32'h80010000, 0, 0));
    dir.push_back(mk(0, -1, 32767, 1, qrs_pkg::KIND_ONE, 32'h7fff0000, 0, 0));
    dir.push_back(mk(0, 256, 0, 1, qrs_pkg::KIND_ONE));
    dir.push_back(mk(256, 0, 256, 1, qrs_pkg::KIND_NONE));
    dir.push_back(mk(256, -512, 256, 1, qrs_pkg::KIND_ONE, 32'h10000));
    dir.push_back(mk(256, 0, -1024, 1, qrs_pkg::KIND_TWO, 32'hfffe0000, 32'h20000));
    dir.push_back(mk(1, -32768, -32768, 1, qrs_pkg::KIND_TWO, 32'hffff0002, 32'h7fffffff, 1));
    dir.push_back(mk(1, 32767, 0, 1, qrs_pkg::KIND_TWO, 32'h80010000, 0, 0));
    dir.push_back(mk(-32768, -32768, -32768));
    dir.push_back(mk(32767, 32767, 32767));
    dir.push_back(mk(32767, -32768, -32768));
    dir.push_back(mk(-32768, 32767, 32767));
    dir.push_back(mk(-1, 3, 7));
    dir.push_back(mk(-256, 0, 0));
    dir.push_back(mk(1, 0, 0));
    dir.push_back(mk(-5, 1000, -20000));
    foreach (dir[i]) send_triple(dir[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 2) != 0) begin
        // build from chosen integer roots so the real-root paths get most traffic
        a = $signed($urandom_range(0, 32)) - 16;
        if (a == 0) a = 1;
        r1 = $signed($urandom_range(0, 40)) - 20;
        r2 = $urandom_range(0, 3) == 0 ? r1 : $signed($urandom_range(0, 40)) - 20;
        k = $urandom_range(0, 4);
        t = mk((a << k) , -(a * (r1 + r2)) << k, (a * r1 * r2) << k);
        t.b ^= CW'($urandom_range(0, 1));
      end else begin
        t = mk(0, 0, 0);
        t.a = rnd_coef();
        t.b = rnd_coef();
        t.c = rnd_coef();
      end
      send_triple(t);
    end
    in_tvalid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed && expected_roots.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver.sv
rtl/core/qrs_checker.sv
bench/tb_quadratic_root_solver.sv
